/* hw/rtl/ffds_pkg.sv */
`timescale 1ns / 1ps

package ffds_pkg;

  // Cluster count of one entry: ceil(duration / cluster length) fits 14 bits.
  localparam int CLUS_W   = 14;
  localparam int CLUS_MAX = 8389;

  // Cluster lengths are 125 ms times 16, 32, 32 or 64.
  // ceil(x/125) = floor((x+124) * RECIP_125 / 2^32) for x below 2^25.
  localparam logic [24:0] RND_125   = 25'd124;
  localparam logic [25:0] RECIP_125 = 26'd34359739;

  localparam logic [15:0] CAP_RESET = 16'd2400;

  // Configuration register indexes
  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_KEEP     = 1'b1;

  function automatic logic [2:0] clus_shift(input logic [1:0] mode);
    logic [2:0] sh;
    case (mode)
      2'd0:    sh = 3'd4;
      2'd1:    sh = 3'd5;
      2'd2:    sh = 3'd5;
      default: sh = 3'd6;
    endcase
    return sh;
  endfunction

endpackage

/* hw/rtl/ffds_if.sv */
`timescale 1ns / 1ps

interface ffds_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] track_ms;
  logic [1:0]  mode;
  logic [15:0] album_tag;
  logic        last_entry;

  modport source (output valid, track_ms, mode, album_tag, last_entry, input ready);
  modport sink   (input valid, track_ms, mode, album_tag, last_entry, output ready);
endinterface

interface ffds_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] entry_index;
  logic [3:0] disc;
  logic       list_done;
  logic [3:0] discs_used;
  logic [6:0] unplaced_count;

  modport source (output valid, entry_index, disc, list_done, discs_used, unplaced_count,
                  input ready);
  modport sink   (input valid, entry_index, disc, list_done, discs_used, unplaced_count,
                  output ready);
endinterface

/* hw/rtl/ffds_clus.sv */
`timescale 1ns / 1ps

// Two-stage cluster count: reciprocal multiply by 1/125, then a rounding-up shift, at least one cluster.
module ffds_clus (
  input  logic                        clk,
  input  logic [23:0]                 dur,
  input  logic [1:0]                  mode,
  output logic [ffds_pkg::CLUS_W-1:0] clus
);

  logic [50:0] prod_r;
  logic [1:0]  mode_r;
  logic [18:0] q;
  logic [2:0]  sh;
  logic [19:0] mask;
  logic [19:0] c_wide;
  logic [ffds_pkg::CLUS_W-1:0] clus_nxt;
  logic [ffds_pkg::CLUS_W-1:0] clus_r;

  always_ff @(posedge clk) begin
    prod_r <= 51'(25'(dur) + ffds_pkg::RND_125) * 51'(ffds_pkg::RECIP_125);
    mode_r <= mode;
  end

  always_comb begin
    q        = prod_r[50:32];
    sh       = ffds_pkg::clus_shift(mode_r);
    mask     = (20'd1 << sh) - 20'd1;
    c_wide   = (20'(q) + mask) >> sh;
    clus_nxt = c_wide[ffds_pkg::CLUS_W-1:0];
    if (clus_nxt == '0) clus_nxt = ffds_pkg::CLUS_W'(1);
  end

  always_ff @(posedge clk) begin
    clus_r <= clus_nxt;
  end

  assign clus = clus_r;

endmodule

/* hw/rtl/first_fit_disc_splitter.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Payload
// in_req    in   valid/ready    track_ms, mode, album_tag, last_entry
// out_res   out  valid/ready    entry_index, disc, list_done, discs_used, unplaced_count
// cfg_*     in   cfg_we only    cfg_index (0 capacity, 1 keep_albums), cfg_wdata
//
// Sequence: one request is taken at a time. Intake steps are latch, the two cluster
//   stages, decide and append. Each placement try of a run starts, then walks the open
//   discs through the disc memory with a read and a compare step per disc, and ends in
//   a write step on a hit or when a disc is opened, or in a fail step; a split retry
//   adds one run memory read and another walk. The emit step passes out the results of
//   a try one after another; a flush ends with one more start step.
// Reset: synchronous, active low. Disc memory entries carry valid bits, so there is
//   no clearing pass; the run memory is only read below the run length.
// Stalls: results leave through an output register; a stalled output holds the
//   sequencer in its emit step. A new request is taken while the last result waits.
module first_fit_disc_splitter #(
  parameter int ENTRY_MAX = 64,
  parameter int DISC_MAX  = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  ffds_in_if.sink           in_req,
  ffds_out_if.source        out_res,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_wdata
);

  localparam int EW  = $clog2(ENTRY_MAX + 1);             // entry counts
  localparam int AW  = (ENTRY_MAX > 1) ? $clog2(ENTRY_MAX) : 1;
  localparam int DCW = $clog2(DISC_MAX + 1);              // disc counts
  localparam int DW  = (DISC_MAX > 1) ? $clog2(DISC_MAX) : 1;
  localparam int SW  = $clog2(ENTRY_MAX * ffds_pkg::CLUS_MAX + 1);
  localparam int CW  = ((SW > 16) ? SW : 16) + 1;         // compare width
  localparam int KW  = ffds_pkg::CLUS_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_OVER  = 4'd1;   // list too long: unplaced at once
  localparam logic [3:0] S_C1    = 4'd2;
  localparam logic [3:0] S_C2    = 4'd3;
  localparam logic [3:0] S_DEC   = 4'd4;
  localparam logic [3:0] S_APP   = 4'd5;
  localparam logic [3:0] F_START = 4'd6;
  localparam logic [3:0] F_SCAN  = 4'd7;
  localparam logic [3:0] F_CHK   = 4'd8;
  localparam logic [3:0] F_FAIL  = 4'd9;
  localparam logic [3:0] F_RDC   = 4'd10;
  localparam logic [3:0] F_WR    = 4'd11;
  localparam logic [3:0] F_EMIT  = 4'd12;
  localparam logic [3:0] F_EMITU = 4'd13;

  // ---- configuration
  logic [15:0] cap_r;
  logic        keep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= ffds_pkg::CAP_RESET;
      keep_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        ffds_pkg::CFG_CAPACITY: cap_r  <= cfg_wdata;
        ffds_pkg::CFG_KEEP:     keep_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---- request latch (payload)
  logic [23:0] dur_r, dur_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [15:0] album_r, album_nxt;
  logic        last_r, last_nxt;

  logic [KW-1:0] clus;

  ffds_clus u_clus (
    .clk  (clk),
    .dur  (dur_r),
    .mode (mode_r),
    .clus (clus)
  );

  // ---- control state
  logic [3:0]     state_r, state_nxt;
  logic [EW-1:0]  run_len_r, run_len_nxt;
  logic [15:0]    run_album_r, run_album_nxt;
  logic [AW-1:0]  run_first_r, run_first_nxt;
  logic [SW-1:0]  rem_sum_r, rem_sum_nxt;     // clusters not yet placed in run
  logic [DCW-1:0] disc_open_r, disc_open_nxt;
  logic           gave_up_r, gave_up_nxt;
  logic [EW-1:0]  seen_r, seen_nxt;
  logic [6:0]     unpl_r, unpl_nxt;
  logic [EW-1:0]  pos_r, pos_nxt;
  logic [SW-1:0]  try_sum_r, try_sum_nxt;
  logic [EW-1:0]  try_cnt_r, try_cnt_nxt;     // doubles as emit countdown
  logic           single_r, single_nxt;
  logic [DCW-1:0] d_r, d_nxt;
  logic [DW-1:0]  t_r, t_nxt;
  logic [15:0]    cur_fill_r, cur_fill_nxt;
  logic [EW-1:0]  cur_ent_r, cur_ent_nxt;
  logic           phase_b_r, phase_b_nxt;     // 1: flush after the append
  logic [DISC_MAX-1:0] disc_vld_r;

  // ---- memories
  logic [KW-1:0]    run_mem [ENTRY_MAX];
  logic [KW-1:0]    rd_run_r;
  logic             run_we;
  logic [16+EW-1:0] disc_mem [DISC_MAX];
  logic [16+EW-1:0] rd_disc_r;
  logic             rd_vld_r;
  logic             disc_we;
  logic [15:0]      new_fill;
  logic [EW-1:0]    new_ent;

  // Accesses never overlap on one entry: a disc write is followed by at least
  // an emit and a start step before the next disc read, and a run entry is
  // read only after its append.
  always_ff @(posedge clk) begin
    if (run_we) run_mem[run_len_r[AW-1:0]] <= clus;
    rd_run_r <= run_mem[pos_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (disc_we) disc_mem[t_r] <= {new_fill, new_ent};
    rd_disc_r <= disc_mem[d_r[DW-1:0]];
    rd_vld_r  <= disc_vld_r[d_r[DW-1:0]];
  end

  assign new_fill = 16'(cur_fill_r + try_sum_r);
  assign new_ent  = cur_ent_r + try_cnt_r;

  // ---- compare logic
  logic [15:0]   rd_fill;
  logic [EW-1:0] rd_ent;
  logic          fits, lone_ok, new_ok, may_run;

  assign rd_fill = rd_vld_r ? rd_disc_r[16+EW-1:EW] : 16'd0;
  assign rd_ent  = rd_vld_r ? rd_disc_r[EW-1:0] : '0;
  assign fits    = (CW'(rd_fill) + CW'(try_sum_r) <= CW'(cap_r)) &&
                   ((EW+1)'(rd_ent) + (EW+1)'(try_cnt_r) <= (EW+1)'(ENTRY_MAX));
  assign lone_ok = (rd_ent == '0) && (try_cnt_r == EW'(1));
  assign new_ok  = (disc_open_r < DCW'(DISC_MAX)) &&
                   ((CW'(try_sum_r) <= CW'(cap_r)) || (try_cnt_r == EW'(1)));
  assign may_run = keep_r && (album_r != 16'd0);

  // ---- result formatting
  logic          out_free, emit, emit_unpl, emit_done;
  logic [5:0]    emit_idx;
  logic [3:0]    emit_disc;
  logic [6:0]    unpl_inc;
  logic [6:0]    unpl_emit;                   // count including this result
  logic [AW-1:0] run_idx;
  logic [AW+5:0] idx_ext;
  logic [DW+3:0] t_ext;
  logic [DCW+3:0] open_ext;
  logic [AW+5:0] over_ext;
  logic          run_final;
  logic          clear_list;

  assign out_free  = !out_res.valid || out_res.ready;
  assign unpl_inc  = (unpl_r == 7'd127) ? unpl_r : unpl_r + 7'd1;
  assign unpl_emit = emit_unpl ? unpl_inc : unpl_r;
  assign run_idx   = run_first_r + pos_r[AW-1:0];
  assign idx_ext   = {6'd0, run_idx};
  assign over_ext  = {6'd0, AW'(ENTRY_MAX - 1)};
  assign t_ext     = {4'd0, t_r};
  assign open_ext  = {4'd0, disc_open_r};
  assign run_final = last_r && phase_b_r && ((pos_r + EW'(1)) == run_len_r);

  assign in_req.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    dur_nxt       = dur_r;
    mode_nxt      = mode_r;
    album_nxt     = album_r;
    last_nxt      = last_r;
    run_len_nxt   = run_len_r;
    run_album_nxt = run_album_r;
    run_first_nxt = run_first_r;
    rem_sum_nxt   = rem_sum_r;
    disc_open_nxt = disc_open_r;
    gave_up_nxt   = gave_up_r;
    seen_nxt      = seen_r;
    unpl_nxt      = unpl_r;
    pos_nxt       = pos_r;
    try_sum_nxt   = try_sum_r;
    try_cnt_nxt   = try_cnt_r;
    single_nxt    = single_r;
    d_nxt         = d_r;
    t_nxt         = t_r;
    cur_fill_nxt  = cur_fill_r;
    cur_ent_nxt   = cur_ent_r;
    phase_b_nxt   = phase_b_r;
    run_we        = 1'b0;
    disc_we       = 1'b0;
    emit          = 1'b0;
    emit_unpl     = 1'b0;
    emit_done     = 1'b0;
    emit_idx      = idx_ext[5:0];
    emit_disc     = t_ext[3:0];
    clear_list    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          dur_nxt   = in_req.track_ms;
          mode_nxt  = in_req.mode;
          album_nxt = in_req.album_tag;
          last_nxt  = in_req.last_entry;
          state_nxt = (seen_r >= EW'(ENTRY_MAX)) ? S_OVER : S_C1;
        end
      end
      S_OVER: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_unpl  = 1'b1;
          emit_idx   = over_ext[5:0];
          emit_disc  = 4'(DISC_MAX);
          emit_done  = last_r;
          clear_list = last_r;
          state_nxt  = S_IDLE;
        end
      end
      S_C1: state_nxt = S_C2;
      S_C2: state_nxt = S_DEC;
      S_DEC: begin
        if (may_run && (run_len_r != '0) && (album_r == run_album_r)) begin
          state_nxt = S_APP;
        end else begin
          phase_b_nxt = 1'b0;
          pos_nxt     = '0;
          state_nxt   = F_START;
        end
      end
      S_APP: begin
        if (run_len_r == '0) run_first_nxt = seen_r[AW-1:0];
        run_we        = 1'b1;
        run_len_nxt   = run_len_r + EW'(1);
        rem_sum_nxt   = rem_sum_r + SW'(clus);
        run_album_nxt = may_run ? album_r : 16'd0;
        seen_nxt      = seen_r + EW'(1);
        if (last_r || ((seen_r + EW'(1)) == EW'(ENTRY_MAX)) || !may_run) begin
          phase_b_nxt = 1'b1;
          pos_nxt     = '0;
          state_nxt   = F_START;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      F_START: begin
        if (pos_r == run_len_r) begin
          run_len_nxt   = '0;
          run_album_nxt = 16'd0;
          rem_sum_nxt   = '0;
          if (!phase_b_r) begin
            state_nxt = S_APP;
          end else begin
            clear_list = last_r;
            state_nxt  = S_IDLE;
          end
        end else if (gave_up_r) begin
          state_nxt = F_EMITU;
        end else begin
          try_sum_nxt = rem_sum_r;
          try_cnt_nxt = run_len_r - pos_r;
          single_nxt  = 1'b0;
          d_nxt       = '0;
          state_nxt   = F_SCAN;
        end
      end
      F_SCAN: begin
        if (d_r < disc_open_r) begin
          state_nxt = F_CHK;
        end else if (new_ok) begin
          t_nxt         = disc_open_r[DW-1:0];
          cur_fill_nxt  = 16'd0;
          cur_ent_nxt   = '0;
          disc_open_nxt = disc_open_r + DCW'(1);
          state_nxt     = F_WR;
        end else begin
          state_nxt = F_FAIL;
        end
      end
      F_CHK: begin
        if (fits || lone_ok) begin
          t_nxt        = d_r[DW-1:0];
          cur_fill_nxt = rd_fill;
          cur_ent_nxt  = rd_ent;
          state_nxt    = F_WR;
        end else begin
          d_nxt     = d_r + DCW'(1);
          state_nxt = F_SCAN;
        end
      end
      F_FAIL: begin
        // split: retry the first unplaced entry of the run alone
        if (!single_r && (try_cnt_r > EW'(1))) begin
          state_nxt = F_RDC;
        end else begin
          gave_up_nxt = 1'b1;
          state_nxt   = F_START;
        end
      end
      F_RDC: begin
        try_sum_nxt = SW'(rd_run_r);
        try_cnt_nxt = EW'(1);
        single_nxt  = 1'b1;
        d_nxt       = '0;
        state_nxt   = F_SCAN;
      end
      F_WR: begin
        disc_we     = 1'b1;
        rem_sum_nxt = rem_sum_r - try_sum_r;
        state_nxt   = F_EMIT;
      end
      F_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_done = run_final;
          pos_nxt   = pos_r + EW'(1);
          if (try_cnt_r == EW'(1)) state_nxt = F_START;
          else                     try_cnt_nxt = try_cnt_r - EW'(1);
        end
      end
      F_EMITU: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_unpl = 1'b1;
          emit_disc = 4'(DISC_MAX);
          emit_done = run_final;
          pos_nxt   = pos_r + EW'(1);
          state_nxt = F_START;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (emit_unpl) unpl_nxt = unpl_inc;

    if (clear_list) begin
      run_len_nxt   = '0;
      run_album_nxt = 16'd0;
      run_first_nxt = '0;
      rem_sum_nxt   = '0;
      disc_open_nxt = DCW'(1);
      gave_up_nxt   = 1'b0;
      seen_nxt      = '0;
      unpl_nxt      = 7'd0;
      pos_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_len_r   <= '0;
      run_album_r <= 16'd0;
      run_first_r <= '0;
      rem_sum_r   <= '0;
      disc_open_r <= DCW'(1);
      gave_up_r   <= 1'b0;
      seen_r      <= '0;
      unpl_r      <= 7'd0;
      pos_r       <= '0;
      single_r    <= 1'b0;
      phase_b_r   <= 1'b0;
      disc_vld_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      run_len_r   <= run_len_nxt;
      run_album_r <= run_album_nxt;
      run_first_r <= run_first_nxt;
      rem_sum_r   <= rem_sum_nxt;
      disc_open_r <= disc_open_nxt;
      gave_up_r   <= gave_up_nxt;
      seen_r      <= seen_nxt;
      unpl_r      <= unpl_nxt;
      pos_r       <= pos_nxt;
      single_r    <= single_nxt;
      phase_b_r   <= phase_b_nxt;
      if (clear_list)   disc_vld_r     <= '0;
      else if (disc_we) disc_vld_r[t_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    dur_r      <= dur_nxt;
    mode_r     <= mode_nxt;
    album_r    <= album_nxt;
    last_r     <= last_nxt;
    try_sum_r  <= try_sum_nxt;
    try_cnt_r  <= try_cnt_nxt;
    d_r        <= d_nxt;
    t_r        <= t_nxt;
    cur_fill_r <= cur_fill_nxt;
    cur_ent_r  <= cur_ent_nxt;
  end

  // ---- output register
  logic       out_valid_r;
  logic [5:0] out_idx_r;
  logic [3:0] out_disc_r;
  logic       out_done_r;
  logic [3:0] out_used_r;
  logic [6:0] out_unpl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_idx_r  <= emit_idx;
      out_disc_r <= emit_disc;
      out_done_r <= emit_done;
      out_used_r <= open_ext[3:0];
      out_unpl_r <= emit_done ? unpl_emit : 7'd0;
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.entry_index    = out_idx_r;
  assign out_res.disc           = out_disc_r;
  assign out_res.list_done      = out_done_r;
  assign out_res.discs_used     = out_used_r;
  assign out_res.unplaced_count = out_unpl_r;

endmodule

/* hw/rtl/ffds_chk.sv */
`timescale 1ns / 1ps

module ffds_chk #(
  parameter int DISC_MAX = 8
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_entry_index,
  input logic [3:0] out_disc,
  input logic       out_list_done,
  input logic [3:0] out_discs_used,
  input logic [6:0] out_unplaced_count
);

  // stalled result holds its index, disc, done flag and unplaced count
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_entry_index) &&
    $stable(out_disc) && $stable(out_list_done) && $stable(out_unplaced_count))
    else $error("result changed while stalled");

  // unplaced count only shows on the final result
  a_unpl_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_list_done |-> out_unplaced_count == 7'd0)
    else $error("unplaced count on a non-final result");

  // a placed entry goes to an opened disc
  a_disc_open: assert property (@(posedge clk) disable iff (!rst_n)
    (DISC_MAX < 16) && out_valid && (out_disc != 4'(DISC_MAX)) |->
    out_disc < out_discs_used)
    else $error("disc beyond discs opened");

  // one request at a time: never ready right after taking one
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

endmodule

bind first_fit_disc_splitter ffds_chk #(.DISC_MAX(DISC_MAX)) u_ffds_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_req.valid),
  .in_ready           (in_req.ready),
  .out_valid          (out_res.valid),
  .out_ready          (out_res.ready),
  .out_entry_index    (out_res.entry_index),
  .out_disc           (out_res.disc),
  .out_list_done      (out_res.list_done),
  .out_discs_used     (out_res.discs_used),
  .out_unplaced_count (out_res.unplaced_count)
);

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int NENT  = 64;
  localparam int NDISC = 8;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [23:0] track_ms;
    logic [1:0]  mode;
    logic [15:0] album_tag;
    logic        last_entry;
  } request_t;

  typedef struct packed {
    logic [5:0] entry_index;
    logic [3:0] disc;
    logic       list_done;
    logic [3:0] discs_used;
    logic [6:0] unplaced_count;
  } placement_t;

  // Directed row: request, plus an optional typed-in first result
  typedef struct {
    request_t   req;
    logic       has_known;
    placement_t known;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = ffds_pkg::CFG_CAPACITY;
  logic [15:0] cfg_wdata = '0;

  ffds_in_if  in_req ();
  ffds_out_if out_res ();

  first_fit_disc_splitter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req.sink),
    .out_res  (out_res.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Packing model: our own copy of the registers and list state
  // ---------------------------------------------------------------------
  logic [15:0] cap_reg;
  logic        keep_reg;
  int unsigned pend_clus [NENT];
  int unsigned pend_len, pend_album, pend_first;
  int unsigned fill_q [NDISC];
  int unsigned count_q [NDISC];
  int unsigned open_discs, seen_total, lost_count;
  bit          stuck;

  placement_t placements_due [$];
  placement_t batch [$];
  int unsigned n_fail = 0;
  int unsigned n_checked = 0;
  int unsigned n_lists = 0;

  function automatic void list_clear();
    for (int i = 0; i < NDISC; i++) begin
      fill_q[i] = 0;
      count_q[i] = 0;
    end
    pend_len = 0;
    pend_album = 0;
    pend_first = 0;
    open_discs = 1;
    stuck = 0;
    seen_total = 0;
    lost_count = 0;
  endfunction

  function automatic void post(int unsigned idx, int unsigned d);
    placement_t p;
    p.entry_index = idx[5:0];
    p.disc = d[3:0];
    p.list_done = 1'b0;
    p.discs_used = open_discs[3:0];
    p.unplaced_count = '0;
    batch.push_back(p);
  endfunction

  function automatic void bump_lost();
    if (lost_count < 127) lost_count++;
  endfunction

  function automatic int unsigned first_fit(int unsigned clus, int unsigned cnt);
    int unsigned d;
    for (d = 0; d < open_discs && d < NDISC; d++) begin
      if (fill_q[d] + clus <= cap_reg && count_q[d] + cnt <= NENT) return d;
      if (count_q[d] == 0 && cnt == 1) return d;
    end
    if (open_discs < NDISC && (clus <= cap_reg || cnt == 1)) begin
      d = open_discs;
      open_discs++;
      return d;
    end
    return NDISC;
  endfunction

  // Decide the buffered run, splitting off the head entry when it fits nowhere
  function automatic void settle_run();
    int unsigned pos, sum, cnt, tgt;
    pos = 0;
    while (pos < pend_len) begin
      if (stuck) begin
        post(pend_first + pos, NDISC);
        bump_lost();
        pos++;
      end else begin
        sum = 0;
        for (int k = pos; k < pend_len; k++) sum += pend_clus[k];
        cnt = pend_len - pos;
        tgt = first_fit(sum, cnt);
        if (tgt == NDISC && cnt > 1) begin
          cnt = 1;
          sum = pend_clus[pos];
          tgt = first_fit(sum, 1);
        end
        if (tgt == NDISC) begin
          stuck = 1;
        end else begin
          fill_q[tgt] += sum;
          count_q[tgt] += cnt;
          for (int k = 0; k < cnt; k++) post(pend_first + pos + k, tgt);
          pos += cnt;
        end
      end
    end
    pend_len = 0;
    pend_album = 0;
  endfunction

  function automatic void predict_placements(request_t r);
    int unsigned ms, c;
    bit joinable;
    batch.delete();
    if (seen_total >= NENT) begin
      post(NENT - 1, NDISC);
      bump_lost();
    end else begin
      case (r.mode)
        2'd0:    ms = 2000;
        2'd1,
        2'd2:    ms = 4000;
        default: ms = 8000;
      endcase
      c = (int'(r.track_ms) + ms - 1) / ms;
      if (c == 0) c = 1;
      joinable = keep_reg && r.album_tag != 0;
      if (!(joinable && pend_len > 0 && r.album_tag == pend_album)) settle_run();
      if (pend_len == 0) pend_first = seen_total;
      if (pend_len < NENT) begin
        pend_clus[pend_len] = c;
        pend_len++;
      end
      pend_album = joinable ? r.album_tag : 0;
      seen_total++;
      if (r.last_entry || seen_total >= NENT || !joinable) settle_run();
    end
    if (r.last_entry && batch.size() > 0) begin
      batch[$].list_done = 1'b1;
      batch[$].unplaced_count = lost_count[6:0];
      list_clear();
      n_lists++;
    end
    foreach (batch[i]) placements_due.push_back(batch[i]);
  endfunction

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------
  bit idle_on = 1;
  bit hold_off = 0;
  int unsigned idle_cycles = 0;
  int unsigned quiet_cycles = 0;

  // Offer one request; may insert a random idle burst before it.
  // valid stays up after a handshake until an idle burst or a drain drops it.
  task automatic send_request(request_t r);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.track_ms <= r.track_ms;
    in_req.mode <= r.mode;
    in_req.album_tag <= r.album_tag;
    in_req.last_entry <= r.last_entry;
    do @(posedge clk); while (!(in_req.valid && in_req.ready));
    predict_placements(r);
  endtask

  task automatic wait_drained();
    in_req.valid <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ffds_pkg::CFG_CAPACITY) cap_reg = val;
    else keep_reg = val[0];
    @(posedge clk);
  endtask

  function automatic request_t mk(int unsigned dur, int unsigned md, int unsigned alb,
                                  bit lst);
    request_t r;
    r.track_ms = dur[23:0];
    r.mode = md[1:0];
    r.album_tag = alb[15:0];
    r.last_entry = lst;
    return r;
  endfunction

  // Random list: mostly album runs, with album-0 singles mixed in
  task automatic random_list(int unsigned len, int unsigned max_dur);
    int unsigned alb;
    alb = $urandom_range(1, 65535);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 3) == 0) alb = $urandom_range(0, 2) == 0 ? 0 :
                                            $urandom_range(1, 65535);
      send_request(mk($urandom_range(0, max_dur), $urandom_range(0, 3), alb,
                      i == len - 1));
    end
  endtask

  directed_row_t rows [$];
  placement_t kn;

  initial begin
    in_req.valid <= 1'b0;
    in_req.track_ms <= '0;
    in_req.mode <= '0;
    in_req.album_tag <= '0;
    in_req.last_entry <= 1'b0;
    cap_reg = ffds_pkg::CAP_RESET;
    keep_reg = 1'b1;
    list_clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Known first result typed in where it is obvious.
    kn = '{entry_index: 6'd0, disc: 4'd0, list_done: 1'b0, discs_used: 4'd1,
           unplaced_count: 7'd0};
    rows.push_back('{mk(0, 0, 0, 0), 1, kn});              // zero length, one cluster
    rows.push_back('{mk(24'hFFFFFF, 3, 0, 0), 0, kn});    // longest entries; oversized in mode 0
    rows.push_back('{mk(24'hFFFFFF, 0, 0, 0), 0, kn});
    rows.push_back('{mk(1, 1, 16'hFFFF, 0), 0, kn});      // album run
    rows.push_back('{mk(3999, 2, 16'hFFFF, 0), 0, kn});
    rows.push_back('{mk(4001, 1, 16'hFFFF, 0), 0, kn});
    rows.push_back('{mk(2001, 0, 1, 0), 0, kn});          // album change closes run
    rows.push_back('{mk(8000, 3, 1, 0), 0, kn});
    rows.push_back('{mk(24'h555555, 2, 0, 0), 0, kn});
    rows.push_back('{mk(24'hAAAAAA, 1, 16'h5555, 0), 0, kn});
    rows.push_back('{mk(24'h7FFFFF, 0, 16'hAAAA, 0), 0, kn});
    rows.push_back('{mk(4800000, 0, 7, 0), 0, kn});        // fills a disc exactly
    rows.push_back('{mk(4800000, 0, 7, 0), 0, kn});
    rows.push_back('{mk(9600000, 3, 0, 1), 0, kn});        // end of list
    kn.list_done = 1'b1;
    rows.push_back('{mk(500, 0, 0, 1), 1, kn});            // one-entry list

    foreach (rows[i]) begin
      send_request(rows[i].req);
      if (rows[i].has_known && batch.size() > 0) begin
        if (batch[0] != rows[i].known) begin
          $error("directed row %0d placement: expected %h, model gives %h", i,
                 rows[i].known, batch[0]);
          n_fail++;
        end
      end
    end
    wait_drained();

    // Capacity extremes and album keeping off; a list longer than 64 entries
    write_reg(ffds_pkg::CFG_CAPACITY, 16'd1);
    write_reg(ffds_pkg::CFG_KEEP, 16'd0);
    random_list(12, 20000);
    wait_drained();
    write_reg(ffds_pkg::CFG_CAPACITY, 16'd0);
    random_list(6, 5000);
    wait_drained();
    write_reg(ffds_pkg::CFG_CAPACITY, 16'hFFFF);
    write_reg(ffds_pkg::CFG_KEEP, 16'd1);
    for (int i = 0; i < 68; i++)
      send_request(mk($urandom_range(0, 9000), $urandom_range(0, 3), 16'd3, i == 67));
    wait_drained();

    // Random lists under small capacities so discs overflow, then at capacity 2400
    write_reg(ffds_pkg::CFG_CAPACITY, 16'd40);
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      random_list(15, 60000);
    join
    wait_drained();
    write_reg(ffds_pkg::CFG_CAPACITY, 16'(($urandom_range(5, 300))));
    random_list(14, 100000);
    random_list(10, 400000);
    wait_drained();
    write_reg(ffds_pkg::CFG_KEEP, 16'd0);
    write_reg(ffds_pkg::CFG_CAPACITY, 16'd2400);
    random_list(12, 24'hFFFFFF);
    wait_drained();
    write_reg(ffds_pkg::CFG_KEEP, 16'd1);
    idle_on = 0;
    random_list(16, 200000);
    random_list(5, 1000);
    wait_drained();

    $display("Checked %0d placements over %0d lists (capacity 0..65535, albums on/off,",
             n_checked, n_lists);
    $display("  overlong list, oversized entries, output hold-off).");
    if (n_fail == 0) $display("** first_fit_disc_splitter: PASSED **");
    else $display("** first_fit_disc_splitter: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result side: random ready bursts, long hold-off on request
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_res.ready <= 1'b0;
      idle_cycles <= 0;
    end else if (hold_off) begin
      out_res.ready <= 1'b0;
    end else if (idle_cycles != 0) begin
      idle_cycles <= idle_cycles - 1;
      out_res.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      idle_cycles <= $urandom_range(1, 13) - 1;
      out_res.ready <= 1'b0;
    end else begin
      out_res.ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    placement_t got, want;
    if (rst_n && out_res.valid && out_res.ready) begin
      got.entry_index = out_res.entry_index;
      got.disc = out_res.disc;
      got.list_done = out_res.list_done;
      got.discs_used = out_res.discs_used;
      got.unplaced_count = out_res.unplaced_count;
      if (placements_due.size() == 0) begin
        $error("unexpected result %h", got);
        n_fail++;
      end else begin
        want = placements_due.pop_front();
        n_checked++;
        if (got.entry_index != want.entry_index) begin
          $error("entry_index: expected %0d, got %0d", want.entry_index, got.entry_index);
          n_fail++;
        end
        if (got.disc != want.disc) begin
          $error("disc: expected %0d, got %0d", want.disc, got.disc);
          n_fail++;
        end
        if (got.list_done != want.list_done) begin
          $error("list_done: expected %0d, got %0d", want.list_done, got.list_done);
          n_fail++;
        end
        if (got.discs_used != want.discs_used) begin
          $error("discs_used: expected %0d, got %0d", want.discs_used, got.discs_used);
          n_fail++;
        end
        if (got.unplaced_count != want.unplaced_count) begin
          $error("unplaced_count: expected %0d, got %0d", want.unplaced_count,
                 got.unplaced_count);
          n_fail++;
        end
      end
    end
  end

  // Watchdog: cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready) || cfg_we ||
        (placements_due.size() == 0 && !in_req.valid))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** first_fit_disc_splitter: FAILED **");
      $finish;
    end
  end

endmodule

/* files.f */
hw/rtl/ffds_pkg.sv
hw/rtl/ffds_if.sv
hw/rtl/ffds_clus.sv
hw/rtl/first_fit_disc_splitter.sv
hw/rtl/ffds_chk.sv
sim/tb_top.sv
